// ===== rtl/bvg_pkg.sv =====
// Shared types, widths and constants of the battery voltage gauge.
// Includes the fixed charge curve and the configuration register indexes.
// Used by the channel interfaces, the serial divider and the top level.
package bvg_pkg;

  localparam int MV_W       = 16;
  localparam int PCT_W      = 7;
  localparam int BST_W      = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int HIST_DEPTH = 8;
  localparam int HIST_IDX_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int SUM_W      = MV_W + CNT_W;

  localparam int CURVE_POINTS = 101;
  localparam int CURVE_LAST   = CURVE_POINTS - 1;
  localparam int CURVE_IDX_W  = $clog2(CURVE_POINTS);
  localparam int CURVE_FIRST  = 3580;
  localparam int CURVE_TOP    = 4160;
  localparam int SPAN_CURVE   = CURVE_TOP - CURVE_FIRST;
  localparam int SPAN_W       = $clog2(SPAN_CURVE + 1);
  localparam int PROD_W       = MV_W + SPAN_W;

  localparam int DIV_NUM_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int DIV_DEN_W = MV_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  typedef logic [MV_W-1:0]      mv_t;
  typedef logic [PCT_W-1:0]     pct_t;
  typedef logic [BST_W-1:0]     bst_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [DIV_NUM_W-1:0] div_num_t;
  typedef logic [DIV_DEN_W-1:0] div_den_t;

  localparam cfg_idx_t REG_EMPTY_LEVEL    = 8'd0;
  localparam cfg_idx_t REG_FULL_LEVEL     = 8'd1;
  localparam cfg_idx_t REG_CHARGING_LEVEL = 8'd2;
  localparam cfg_idx_t REG_EXT_POWER      = 8'd3;

  localparam bst_t BAT_NORMAL    = 2'd0;
  localparam bst_t BAT_CHARGING  = 2'd1;
  localparam bst_t BAT_EXT_POWER = 2'd2;
  localparam bst_t BAT_EMPTY     = 2'd3;

  localparam mv_t RST_EMPTY_LEVEL    = 16'd3300;
  localparam mv_t RST_FULL_LEVEL     = 16'd4200;
  localparam mv_t RST_CHARGING_LEVEL = 16'd4300;
  localparam mv_t RST_EXT_POWER      = 16'd4500;

  localparam pct_t PCT_FULL = PCT_W'(CURVE_LAST);

  localparam mv_t CURVE_MV [0:CURVE_LAST] = '{
    16'd3580, 16'd3592, 16'd3600, 16'd3616, 16'd3624, 16'd3628, 16'd3632, 16'd3636,
    16'd3644, 16'd3648, 16'd3652, 16'd3656, 16'd3660, 16'd3664, 16'd3668, 16'd3672,
    16'd3676, 16'd3680, 16'd3684, 16'd3688, 16'd3692, 16'd3691, 16'd3696, 16'd3700,
    16'd3704, 16'd3708, 16'd3712, 16'd3716, 16'd3720, 16'd3724, 16'd3728, 16'd3729,
    16'd3730, 16'd3731, 16'd3733, 16'd3732, 16'd3736, 16'd3740, 16'd3744, 16'd3748,
    16'd3752, 16'd3756, 16'd3760, 16'd3764, 16'd3768, 16'd3772, 16'd3776, 16'd3780,
    16'd3784, 16'd3788, 16'd3792, 16'd3796, 16'd3800, 16'd3804, 16'd3808, 16'd3812,
    16'd3816, 16'd3824, 16'd3828, 16'd3832, 16'd3840, 16'd3848, 16'd3856, 16'd3860,
    16'd3864, 16'd3876, 16'd3880, 16'd3884, 16'd3888, 16'd3892, 16'd3904, 16'd3912,
    16'd3916, 16'd3924, 16'd3928, 16'd3936, 16'd3940, 16'd3948, 16'd3956, 16'd3964,
    16'd3980, 16'd3984, 16'd3996, 16'd4008, 16'd4020, 16'd4032, 16'd4040, 16'd4052,
    16'd4060, 16'd4072, 16'd4088, 16'd4092, 16'd4100, 16'd4108, 16'd4112, 16'd4120,
    16'd4132, 16'd4140, 16'd4144, 16'd4156, 16'd4160
  };

endpackage

// ===== rtl/bvg_if.sv =====
// Valid/ready channel interfaces of the battery voltage gauge.
// Sample input, result output and configuration write channels.
// Depends on bvg_pkg for the payload types.
interface bvg_in_if;
  logic          valid;
  logic          ready;
  bvg_pkg::mv_t  voltage_sample;

  modport source (output valid, output voltage_sample, input ready);
  modport sink (input valid, input voltage_sample, output ready);
endinterface

interface bvg_out_if;
  logic          valid;
  logic          ready;
  bvg_pkg::mv_t  mean_voltage;
  bvg_pkg::pct_t charge_percent;
  bvg_pkg::bst_t battery_state;

  modport source (output valid, output mean_voltage, output charge_percent,
                  output battery_state, input ready);
  modport sink (input valid, input mean_voltage, input charge_percent,
                input battery_state, output ready);
endinterface

interface bvg_cfg_if;
  logic              valid;
  logic              ready;
  bvg_pkg::cfg_idx_t addr;
  bvg_pkg::mv_t      data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

// ===== rtl/battery_voltage_gauge_top.sv =====
// Battery voltage gauge top level: sample history, sequencer and result register.
// Depends on bvg_pkg, the channel interfaces in bvg_if.sv and the divider bvg_div.
//
// Each accepted voltage sample enters an eight-entry history line; one result beat
// follows with the mean of the nonzero entries, the charge percentage and the battery
// state. One item is processed at a time, in these steps: accept the sample, sum the
// history one entry per cycle, run the first of two serial divisions of a 26-bit
// numerator, evaluate the levels, scale the mean, run the second division, search
// the curve in up to seven steps and load the output register.
// Means at or below the empty level or at or above the full level skip the second
// division and the search, and an empty history also skips the first. A finished
// result waits in the output register while the next sample is accepted; a second
// result waits in the sequencer until that register is free. Configuration writes
// are always ready and must be issued only while no sample is in flight.
module battery_voltage_gauge_top (
  input logic       clk,
  input logic       rst_n,
  bvg_in_if.sink    in_bus,
  bvg_out_if.source out_bus,
  bvg_cfg_if.sink   cfg_bus
);
  import bvg_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SUM      = 3'd1;
  localparam logic [2:0] ST_DIV_MEAN = 3'd2;
  localparam logic [2:0] ST_EVAL     = 3'd3;
  localparam logic [2:0] ST_MUL      = 3'd4;
  localparam logic [2:0] ST_DIV_MAP  = 3'd5;
  localparam logic [2:0] ST_SEARCH   = 3'd6;
  localparam logic [2:0] ST_OUT      = 3'd7;

  logic [2:0]             state_r, state_nxt;
  mv_t                    hist_r [HIST_DEPTH];
  mv_t                    hist_nxt [HIST_DEPTH];
  logic [HIST_IDX_W-1:0]  sel_r, sel_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  mv_t                    mean_r, mean_nxt;
  mv_t                    diff_r, diff_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  mv_t                    mapped_r, mapped_nxt;
  pct_t                   lo_r, lo_nxt;
  pct_t                   hi_r, hi_nxt;
  pct_t                   pct_r, pct_nxt;
  bst_t                   bst_r, bst_nxt;
  logic                   div_start_r, div_start_nxt;
  logic                   out_valid_r, out_valid_nxt;
  mv_t                    out_mean_r, out_mean_nxt;
  pct_t                   out_pct_r, out_pct_nxt;
  bst_t                   out_bst_r, out_bst_nxt;
  mv_t                    empty_lvl_r, full_lvl_r, chg_lvl_r, ext_lvl_r;

  logic                   in_fire;
  logic [PCT_W:0]         mid_sum;
  logic [CURVE_IDX_W-1:0] mid;
  div_num_t               div_num;
  div_den_t               div_den;
  div_num_t               div_quo;
  logic                   div_done;

  assign in_fire       = in_bus.valid && in_bus.ready;
  assign in_bus.ready  = (state_r == ST_IDLE);
  assign cfg_bus.ready = 1'b1;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} + (PCT_W+1)'(1);
  assign mid     = CURVE_IDX_W'(mid_sum[PCT_W:1]);

  assign div_num = (state_r == ST_DIV_MEAN) ? DIV_NUM_W'(sum_r) : DIV_NUM_W'(prod_r);
  assign div_den = (state_r == ST_DIV_MEAN) ? DIV_DEN_W'(cnt_r)
                                            : DIV_DEN_W'(full_lvl_r - empty_lvl_r);

  bvg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    hist_nxt      = hist_r;
    sel_nxt       = sel_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    mean_nxt      = mean_r;
    diff_nxt      = diff_r;
    prod_nxt      = prod_r;
    mapped_nxt    = mapped_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    pct_nxt       = pct_r;
    bst_nxt       = bst_r;
    div_start_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    out_mean_nxt  = out_mean_r;
    out_pct_nxt   = out_pct_r;
    out_bst_nxt   = out_bst_r;
    if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          for (int i = HIST_DEPTH - 1; i > 0; i--) begin
            hist_nxt[i] = hist_r[i-1];
          end
          hist_nxt[0] = in_bus.voltage_sample;
          sel_nxt     = '0;
          sum_nxt     = '0;
          cnt_nxt     = '0;
          state_nxt   = ST_SUM;
        end
      end
      ST_SUM: begin
        if (hist_r[sel_r] != '0) begin
          sum_nxt = sum_r + SUM_W'(hist_r[sel_r]);
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        sel_nxt = sel_r + HIST_IDX_W'(1);
        if (sel_r == HIST_IDX_W'(HIST_DEPTH - 1)) begin
          if (cnt_nxt == '0) begin
            mean_nxt  = '0;
            state_nxt = ST_EVAL;
          end else begin
            div_start_nxt = 1'b1;
            state_nxt     = ST_DIV_MEAN;
          end
        end
      end
      ST_DIV_MEAN: begin
        if (div_done) begin
          mean_nxt  = div_quo[MV_W-1:0];
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        priority if (mean_r == '0) begin
          bst_nxt = BAT_NORMAL;
        end else if (mean_r >= ext_lvl_r) begin
          bst_nxt = BAT_EXT_POWER;
        end else if (mean_r >= chg_lvl_r) begin
          bst_nxt = BAT_CHARGING;
        end else if (mean_r >= empty_lvl_r) begin
          bst_nxt = BAT_NORMAL;
        end else begin
          bst_nxt = BAT_EMPTY;
        end
        priority if (mean_r == '0 || mean_r <= empty_lvl_r) begin
          pct_nxt   = '0;
          state_nxt = ST_OUT;
        end else if (mean_r >= full_lvl_r) begin
          pct_nxt   = PCT_FULL;
          state_nxt = ST_OUT;
        end else begin
          diff_nxt  = mean_r - empty_lvl_r;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt      = PROD_W'(diff_r) * PROD_W'(SPAN_CURVE);
        div_start_nxt = 1'b1;
        state_nxt     = ST_DIV_MAP;
      end
      ST_DIV_MAP: begin
        if (div_done) begin
          mapped_nxt = MV_W'(CURVE_FIRST) + div_quo[MV_W-1:0];
          lo_nxt     = '0;
          hi_nxt     = PCT_FULL;
          state_nxt  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (lo_r >= hi_r) begin
          pct_nxt   = lo_r;
          state_nxt = ST_OUT;
        end else if (CURVE_MV[mid] <= mapped_r) begin
          lo_nxt = PCT_W'(mid);
        end else begin
          hi_nxt = PCT_W'(mid) - PCT_W'(1);
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = mean_r;
          out_pct_nxt   = pct_r;
          out_bst_nxt   = bst_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
      hist_r      <= hist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r      <= sel_nxt;
    sum_r      <= sum_nxt;
    cnt_r      <= cnt_nxt;
    mean_r     <= mean_nxt;
    diff_r     <= diff_nxt;
    prod_r     <= prod_nxt;
    mapped_r   <= mapped_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    pct_r      <= pct_nxt;
    bst_r      <= bst_nxt;
    out_mean_r <= out_mean_nxt;
    out_pct_r  <= out_pct_nxt;
    out_bst_r  <= out_bst_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_lvl_r <= RST_EMPTY_LEVEL;
      full_lvl_r  <= RST_FULL_LEVEL;
      chg_lvl_r   <= RST_CHARGING_LEVEL;
      ext_lvl_r   <= RST_EXT_POWER;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      unique case (cfg_bus.addr)
        REG_EMPTY_LEVEL:    empty_lvl_r <= cfg_bus.data;
        REG_FULL_LEVEL:     full_lvl_r  <= cfg_bus.data;
        REG_CHARGING_LEVEL: chg_lvl_r   <= cfg_bus.data;
        REG_EXT_POWER:      ext_lvl_r   <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.mean_voltage   = out_mean_r;
  assign out_bus.charge_percent = out_pct_r;
  assign out_bus.battery_state  = out_bst_r;

endmodule

// ===== rtl/bvg_div.sv =====
// Restoring serial divider producing one quotient bit per cycle.
// Shared by the mean computation and the curve mapping.
// Depends on bvg_pkg for operand widths.
module bvg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  bvg_pkg::div_num_t num,
  input  bvg_pkg::div_den_t den,
  output logic              done,
  output bvg_pkg::div_num_t quo
);
  import bvg_pkg::*;

  div_num_t               quo_r, quo_nxt;
  div_den_t               rem_r, rem_nxt;
  div_den_t               den_r, den_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [DIV_DEN_W:0]     trial;
  logic [DIV_DEN_W:0]     diff;
  logic                   fits;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    fits     = (trial >= {1'b0, den_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = DIV_CNT_W'(DIV_NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_NUM_W-2:0], fits};
      rem_nxt = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
